FILE: rtl/core/hcp_pkg.sv
// ----------------------------------------------------------------------------
// hcp_pkg
// Types and constants for the heat-map colormap painter: beat payloads,
// register indexes and pixel color classes.
// ----------------------------------------------------------------------------
`default_nettype none

package hcp_pkg;

   typedef struct packed {
      logic        mode;
      logic        start_of_pass;
      logic [15:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic        write_enable;
      logic [19:0] pixel_address;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        end_of_pass;
   } rsp_payload_type;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRAYSCALE_MODE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_USE_FIXED_MAX  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIXED_MAX      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DATA_WIDTH     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DATA_HEIGHT    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_OFFSET       = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_OFFSET       = 3'd6;

   localparam logic        MODE_MEASURE = 1'b0;
   localparam logic [10:0] GRID_MAX     = 11'd1024;

   // pixel color classes
   localparam logic [2:0] CLS_BLANK = 3'd0;
   localparam logic [2:0] CLS_FLAT  = 3'd1;
   localparam logic [2:0] CLS_GRAY  = 3'd2;
   localparam logic [2:0] CLS_WHITE = 3'd3;
   localparam logic [2:0] CLS_SEG0  = 3'd4;
   localparam logic [2:0] CLS_SEG1  = 3'd5;
   localparam logic [2:0] CLS_SEG2  = 3'd6;
   localparam logic [2:0] CLS_SEG3  = 3'd7;

   localparam logic [7:0] CHAN_FULL = 8'd255;
   localparam logic [7:0] CHAN_MID  = 8'd127;
   localparam logic [7:0] CHAN_ZERO = 8'd0;

   localparam int DIV_BITS = 28;
   localparam int Q_BITS   = 8;

endpackage

`default_nettype wire

FILE: rtl/core/heatmap_colormap_painter.sv
// Each accepted request beat steps through the prepare, divide and done states
// before its response beat is registered; no new item is taken until then. The
// shared shift-subtract divider forms the 8 quotient bits of each pixel in turn.
// Request stall is high while an item is in flight or a result cannot be placed.
// Reset (synchronous, active high) clears counters, running max, registers
// to their defaults and drops any pending response.
// ----------------------------------------------------------------------------
// heatmap_colormap_painter
// Measures the maximum of a sample grid, then paints each sample as a
// grayscale or five-color ramp pixel write into a framebuffer.
// ----------------------------------------------------------------------------
`default_nettype none

module heatmap_colormap_painter
   import hcp_pkg::*;
#(
   parameter int FRAME_WIDTH  = 1024,
   parameter int FRAME_HEIGHT = 1024,
   parameter int SAMPLE_BITS  = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_stall,
   input  wire req_payload_type           req_data,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      rsp_payload_type           rsp_data,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int          SB    = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
   localparam logic [15:0] SMASK = 16'((33'd1 << SB) - 33'd1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   // configuration
   logic        gray_ff;
   logic        use_fixed_ff;
   logic [15:0] fixed_max_ff;
   logic [10:0] data_width_ff;
   logic [10:0] data_height_ff;
   logic [9:0]  x_offset_ff;
   logic [9:0]  y_offset_ff;

   // pass state
   logic [15:0] running_max_ff, running_max_in;
   logic [9:0]  col_count_ff, col_count_in;
   logic [9:0]  row_count_ff, row_count_in;

   // sequencer
   logic [1:0]  state_ff, state_in;
   logic [2:0]  div_cnt_ff, div_cnt_in;

   // captured item
   logic        mode_ff;
   logic        eop_ff;
   logic [15:0] s_ff;
   logic [15:0] m_ff;
   logic [9:0]  pos_col_ff;
   logic [9:0]  pos_row_ff;

   // divider and pixel
   logic [DIV_BITS-1:0] rem_ff, rem_in;
   logic [DIV_BITS-1:0] dvs_ff, dvs_in;
   logic [Q_BITS-1:0]   q_ff, q_in;
   logic [2:0]          cls_ff, cls_in;
   logic [19:0]         addr_ff, addr_in;

   logic                rsp_valid_ff;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   logic        accept;
   logic        out_free;
   logic [10:0] grid_w, grid_h;
   logic [15:0] smp, rmax0, m_sel, s_sat;
   logic [9:0]  col0, row0;
   logic [10:0] col_inc, row_inc;
   logic        eop0;
   logic [10:0] fx, fy;
   logic        in_frame;
   logic [23:0] addr_full;
   logic [17:0] s4, m1, m3;
   logic [17:0] s2;
   logic [25:0] s255, s1020, m510, num;
   logic [DIV_BITS-1:0] sub;
   logic        ge;

   assign grid_w = (data_width_ff == 11'd0) ? 11'd1 :
                   (data_width_ff > GRID_MAX) ? GRID_MAX : data_width_ff;
   assign grid_h = (data_height_ff == 11'd0) ? 11'd1 :
                   (data_height_ff > GRID_MAX) ? GRID_MAX : data_height_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gray_ff        <= 1'b0;
         use_fixed_ff   <= 1'b0;
         fixed_max_ff   <= 16'hFFFF;
         data_width_ff  <= GRID_MAX;
         data_height_ff <= GRID_MAX;
         x_offset_ff    <= 10'd0;
         y_offset_ff    <= 10'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GRAYSCALE_MODE: gray_ff        <= csr_wdata[0];
            CSR_USE_FIXED_MAX:  use_fixed_ff   <= csr_wdata[0];
            CSR_FIXED_MAX:      fixed_max_ff   <= csr_wdata;
            CSR_DATA_WIDTH:     data_width_ff  <= csr_wdata[10:0];
            CSR_DATA_HEIGHT:    data_height_ff <= csr_wdata[10:0];
            CSR_X_OFFSET:       x_offset_ff    <= csr_wdata[9:0];
            CSR_Y_OFFSET:       y_offset_ff    <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // accept: position, running max and saturation
   always_comb begin
      smp   = req_data.sample & SMASK;
      col0  = req_data.start_of_pass ? 10'd0 : col_count_ff;
      row0  = req_data.start_of_pass ? 10'd0 : row_count_ff;
      rmax0 = (req_data.start_of_pass && req_data.mode == MODE_MEASURE) ?
              16'd0 : running_max_ff;
      m_sel = use_fixed_ff ? fixed_max_ff : rmax0;
      s_sat = (smp > m_sel) ? m_sel : smp;
      col_inc = {1'b0, col0} + 11'd1;
      row_inc = {1'b0, row0} + 11'd1;
      eop0  = (row_inc >= grid_h) && (col_inc >= grid_w);

      running_max_in = running_max_ff;
      col_count_in   = col_count_ff;
      row_count_in   = row_count_ff;
      if (accept) begin
         if (req_data.mode == MODE_MEASURE) begin
            running_max_in = (smp > rmax0) ? smp : rmax0;
         end else begin
            running_max_in = rmax0;
         end
         if (row_inc >= grid_h) begin
            row_count_in = 10'd0;
            col_count_in = (col_inc >= grid_w) ? 10'd0 : col_inc[9:0];
         end else begin
            row_count_in = row_inc[9:0];
            col_count_in = col0;
         end
      end
   end

   // pixel setup: frame position, color class, dividend
   always_comb begin
      fx        = {1'b0, pos_col_ff} + {1'b0, x_offset_ff};
      fy        = {1'b0, pos_row_ff} + {1'b0, y_offset_ff};
      in_frame  = ({2'b0, fx} < 13'(FRAME_WIDTH)) && ({2'b0, fy} < 13'(FRAME_HEIGHT));
      addr_full = 24'(fy) * 24'(FRAME_WIDTH) + 24'(fx);
      s4        = {s_ff, 2'b00};
      s2        = {1'b0, s_ff, 1'b0};
      m1        = {2'b00, m_ff};
      m3        = {1'b0, m_ff, 1'b0} + {2'b00, m_ff};
      s255      = {2'b0, s_ff, 8'd0} - {10'd0, s_ff};
      s1020     = {s_ff, 10'd0} - {8'd0, s_ff, 2'b00};
      m510      = {1'b0, m_ff, 9'd0} - {9'd0, m_ff, 1'b0};

      if (mode_ff == MODE_MEASURE || !in_frame) begin
         cls_in = CLS_BLANK;
      end else if (m_ff == 16'd0) begin
         cls_in = CLS_FLAT;
      end else if (gray_ff) begin
         cls_in = CLS_GRAY;
      end else if (s_ff == 16'd0) begin
         cls_in = CLS_WHITE;
      end else if (s4 < m1) begin
         cls_in = CLS_SEG0;
      end else if (s2 < m1) begin
         cls_in = CLS_SEG1;
      end else if (s4 < m3) begin
         cls_in = CLS_SEG2;
      end else begin
         cls_in = CLS_SEG3;
      end

      unique case (cls_in)
         CLS_GRAY: num = s255;
         CLS_SEG0: num = s1020;
         CLS_SEG1: num = m510 - s1020;
         CLS_SEG2: num = s1020 - m510;
         CLS_SEG3: num = {m_ff, 10'd0} - {8'd0, m_ff, 2'b00} - s1020;
         default:  num = 26'd0;
      endcase
      addr_in = (cls_in != CLS_BLANK) ? addr_full[19:0] : 20'd0;
   end

   // shared shift-subtract step
   assign sub = rem_ff - dvs_ff;
   assign ge  = (rem_ff >= dvs_ff);

   always_comb begin
      state_in    = state_ff;
      div_cnt_in  = div_cnt_ff;
      rem_in      = rem_ff;
      dvs_in      = dvs_ff;
      q_in        = q_ff;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            rem_in     = {1'b0, num, 1'b0} + DIV_BITS'(m_ff);
            dvs_in     = DIV_BITS'({m_ff, 1'b0}) << (Q_BITS - 1);
            div_cnt_in = 3'(Q_BITS - 1);
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (ge) begin
               rem_in = sub;
            end
            q_in       = {q_ff[Q_BITS-2:0], ge};
            dvs_in     = dvs_ff >> 1;
            div_cnt_in = div_cnt_ff - 3'd1;
            if (div_cnt_ff == 3'd0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_data_in.write_enable  = (cls_ff != CLS_BLANK);
      rsp_data_in.pixel_address = addr_ff;
      rsp_data_in.end_of_pass   = eop_ff;
      unique case (cls_ff)
         CLS_BLANK: begin
            rsp_data_in.red   = CHAN_ZERO;
            rsp_data_in.green = CHAN_ZERO;
            rsp_data_in.blue  = CHAN_ZERO;
         end
         CLS_FLAT: begin
            rsp_data_in.red   = CHAN_MID;
            rsp_data_in.green = CHAN_MID;
            rsp_data_in.blue  = CHAN_MID;
         end
         CLS_GRAY: begin
            rsp_data_in.red   = q_ff;
            rsp_data_in.green = q_ff;
            rsp_data_in.blue  = q_ff;
         end
         CLS_WHITE: begin
            rsp_data_in.red   = CHAN_FULL;
            rsp_data_in.green = CHAN_FULL;
            rsp_data_in.blue  = CHAN_FULL;
         end
         CLS_SEG0: begin
            rsp_data_in.red   = CHAN_ZERO;
            rsp_data_in.green = q_ff;
            rsp_data_in.blue  = CHAN_FULL;
         end
         CLS_SEG1: begin
            rsp_data_in.red   = CHAN_ZERO;
            rsp_data_in.green = CHAN_FULL;
            rsp_data_in.blue  = q_ff;
         end
         CLS_SEG2: begin
            rsp_data_in.red   = q_ff;
            rsp_data_in.green = CHAN_FULL;
            rsp_data_in.blue  = CHAN_ZERO;
         end
         default: begin
            rsp_data_in.red   = CHAN_FULL;
            rsp_data_in.green = q_ff;
            rsp_data_in.blue  = CHAN_ZERO;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         div_cnt_ff     <= 3'd0;
         running_max_ff <= 16'd0;
         col_count_ff   <= 10'd0;
         row_count_ff   <= 10'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         div_cnt_ff     <= div_cnt_in;
         running_max_ff <= running_max_in;
         col_count_ff   <= col_count_in;
         row_count_ff   <= row_count_in;
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= req_data.mode;
         eop_ff     <= eop0;
         s_ff       <= s_sat;
         m_ff       <= m_sel;
         pos_col_ff <= col0;
         pos_row_ff <= row0;
      end
      if (state_ff == ST_PREP) begin
         cls_ff  <= cls_in;
         addr_ff <= addr_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done step");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_cnt_ff == 3'd0) |=> (state_ff == ST_DONE))
      else $error("divider did not finish after its last step");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && m_ff != 16'd0 && cls_ff != CLS_BLANK)
      |-> (rem_ff < DIV_BITS'({m_ff, 1'b0})))
      else $error("division remainder not below divisor");

   a_blank_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.write_enable) |->
      (rsp_data_ff.pixel_address == 20'd0 && rsp_data_ff.red == CHAN_ZERO &&
       rsp_data_ff.green == CHAN_ZERO && rsp_data_ff.blue == CHAN_ZERO))
      else $error("suppressed write carries nonzero fields");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> !accept)
      else $error("request beat taken while dividing");
`endif

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heatmap_colormap_painter testbench
// Drives measure and paint passes over sample grids of many sizes under several
// register settings, predicts every pixel write in a scoreboard and checks
// each response beat field by field, with random idling on both channels.
// ----------------------------------------------------------------------------

module testbench;
   import hcp_pkg::*;

   localparam int          FRAME_W       = 1024;
   localparam int          FRAME_H       = 1024;
   localparam logic        MODE_PAINT    = 1'b1;
   localparam int          SETTLE_CYCLES = 16;
   localparam int          HOLD_CYCLES   = 400;
   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int          REPORT_LIMIT  = 50;
   localparam int          RANDOM_PHASES = 14;
   localparam int          QUIET_PHASE   = 11;

   class pixel_scoreboard;
      rsp_payload_type expected_pixels[$];
      int unsigned     failures;
      bit              gray_mode;
      bit              fixed_sel;
      bit [15:0]       fixed_peak;
      bit [10:0]       grid_cols;
      bit [10:0]       grid_rows;
      bit [9:0]        col_offset;
      bit [9:0]        row_offset;
      bit [15:0]       peak;
      bit [9:0]        col_pos;
      bit [9:0]        row_pos;

      function new();
         failures   = 0;
         gray_mode  = 1'b0;
         fixed_sel  = 1'b0;
         fixed_peak = 16'hFFFF;
         grid_cols  = GRID_MAX;
         grid_rows  = GRID_MAX;
         col_offset = '0;
         row_offset = '0;
         peak       = '0;
         col_pos    = '0;
         row_pos    = '0;
      endfunction

      static function int unsigned grid_span(bit [10:0] v);
         if (v == 0) return 1;
         if (v > GRID_MAX) return GRID_MAX;
         return v;
      endfunction

      function bit [7:0] round_ratio(bit [63:0] num, bit [63:0] den);
         return 8'((2 * num + den) / (2 * den));
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [CSR_DATA_BITS-1:0] value);
         case (index)
            CSR_GRAYSCALE_MODE: gray_mode  = value[0];
            CSR_USE_FIXED_MAX:  fixed_sel  = value[0];
            CSR_FIXED_MAX:      fixed_peak = value;
            CSR_DATA_WIDTH:     grid_cols  = value[10:0];
            CSR_DATA_HEIGHT:    grid_rows  = value[10:0];
            CSR_X_OFFSET:       col_offset = value[9:0];
            CSR_Y_OFFSET:       row_offset = value[9:0];
            default: ;
         endcase
      endfunction

      function void note_request(req_payload_type req);
         int unsigned     cols, rows, col, row, fx, fy;
         bit [63:0]       s, m;
         bit [7:0]        red, green, blue;
         rsp_payload_type pixel;
         cols  = grid_span(grid_cols);
         rows  = grid_span(grid_rows);
         pixel = '0;
         if (req.start_of_pass) begin
            col_pos = '0;
            row_pos = '0;
            if (req.mode == MODE_MEASURE) peak = '0;
         end
         col = col_pos;
         row = row_pos;
         pixel.end_of_pass = (row + 1 >= rows) && (col + 1 >= cols);
         if (req.mode == MODE_MEASURE) begin
            if (req.sample > peak) peak = req.sample;
         end else begin
            m  = fixed_sel ? fixed_peak : peak;
            s  = req.sample;
            fx = col + col_offset;
            fy = row + row_offset;
            if (s > m) s = m;
            if (m == 0) begin
               red = CHAN_MID; green = CHAN_MID; blue = CHAN_MID;
            end else if (gray_mode) begin
               red   = round_ratio(255 * s, m);
               green = red;
               blue  = red;
            end else if (s == 0) begin
               red = CHAN_FULL; green = CHAN_FULL; blue = CHAN_FULL;
            end else if (4 * s < m) begin
               red = CHAN_ZERO; green = round_ratio(1020 * s, m); blue = CHAN_FULL;
            end else if (2 * s < m) begin
               red = CHAN_ZERO; green = CHAN_FULL; blue = round_ratio(510 * m - 1020 * s, m);
            end else if (4 * s < 3 * m) begin
               red = round_ratio(1020 * s - 510 * m, m); green = CHAN_FULL; blue = CHAN_ZERO;
            end else begin
               red = CHAN_FULL; green = round_ratio(1020 * (m - s), m); blue = CHAN_ZERO;
            end
            if (fx < FRAME_W && fy < FRAME_H) begin
               pixel.write_enable  = 1'b1;
               pixel.pixel_address = 20'(fy * FRAME_W + fx);
               pixel.red           = red;
               pixel.green         = green;
               pixel.blue          = blue;
            end
         end
         row++;
         if (row >= rows) begin
            row = 0;
            col++;
            if (col >= cols) col = 0;
         end
         row_pos = row[9:0];
         col_pos = col[9:0];
         expected_pixels.push_back(pixel);
      endfunction

      function void compare_field(string field, logic [31:0] got, logic [31:0] want);
         if (got !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
         end
      endfunction

      function void check_response(rsp_payload_type rsp);
         rsp_payload_type want;
         if (expected_pixels.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: unexpected response beat: expected none, got %h", $time, rsp);
            return;
         end
         want = expected_pixels.pop_front();
         compare_field("write_enable", rsp.write_enable, want.write_enable);
         compare_field("pixel_address", rsp.pixel_address, want.pixel_address);
         compare_field("red", rsp.red, want.red);
         compare_field("green", rsp.green, want.green);
         compare_field("blue", rsp.blue, want.blue);
         compare_field("end_of_pass", rsp.end_of_pass, want.end_of_pass);
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_payload_type           req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_payload_type           rsp_data;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   pixel_scoreboard sb;
   bit              idling = 1'b1;
   bit              hold_off_pending = 1'b0;
   int unsigned     cycle_count = 0;

   heatmap_colormap_painter #(
      .FRAME_WIDTH (FRAME_W),
      .FRAME_HEIGHT(FRAME_H),
      .SAMPLE_BITS (16)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // beat monitor: inputs are noted before results are checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      end
   end

   // result side: random stall bursts plus one long hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_beat(input logic mode, input logic sop, input logic [15:0] sample);
      req_payload_type item;
      item.mode          = mode;
      item.start_of_pass = sop;
      item.sample        = sample;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic configure(input bit gray, input bit fixed_sel, input logic [15:0] fixed_peak,
                            input logic [10:0] cols, input logic [10:0] rows,
                            input logic [9:0] xoff, input logic [9:0] yoff);
      logic [CSR_INDEX_BITS-1:0] reg_index[7];
      logic [CSR_DATA_BITS-1:0]  field_value[7];
      reg_index   = '{CSR_GRAYSCALE_MODE, CSR_USE_FIXED_MAX, CSR_FIXED_MAX, CSR_DATA_WIDTH,
                      CSR_DATA_HEIGHT, CSR_X_OFFSET, CSR_Y_OFFSET};
      field_value = '{16'(gray), 16'(fixed_sel), fixed_peak, 16'(cols), 16'(rows),
                      16'(xoff), 16'(yoff)};
      req_valid <= 1'b0;
      // let the monitor note the last accepted beat first
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int i = 0; i < 7; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= reg_index[i];
         csr_wdata        <= field_value[i];
         sb.write_register(reg_index[i], field_value[i]);
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [15:0] pick_sample(logic [15:0] ceiling);
      int unsigned v;
      case ($urandom_range(0, 7))
         0: v = 0;
         1: v = ceiling;
         2: v = $urandom_range(0, 65535);
         3: v = (ceiling == 16'hFFFF) ? ceiling : ceiling + $urandom_range(1, 65535 - ceiling);
         4: begin
            // land on or next to a ramp segment bound
            v = ceiling * $urandom_range(1, 3) / 4 + $urandom_range(0, 2);
            v = (v == 0) ? 0 : v - 1;
         end
         default: v = $urandom_range(0, ceiling);
      endcase
      return v[15:0];
   endfunction

   function automatic logic [10:0] pick_dim();
      case ($urandom_range(0, 9))
         0: return 11'd0;
         1: return 11'd1;
         2: return GRID_MAX;
         3: return 11'd2047;
         4: return 11'($urandom_range(1, 2047));
         default: return 11'($urandom_range(1, 8));
      endcase
   endfunction

   task automatic run_pass(input logic mode, input int count);
      logic [15:0] scale;
      logic [15:0] ceiling;
      case ($urandom_range(0, 2))
         0: scale = 16'hFFFF;
         1: scale = 16'($urandom_range(1, 255));
         default: scale = 16'($urandom_range(1, 65535));
      endcase
      for (int i = 0; i < count; i++) begin
         ceiling = sb.fixed_sel ? sb.fixed_peak : sb.peak;
         if (mode == MODE_MEASURE)
            send_beat(mode, i == 0, 16'($urandom_range(0, scale)));
         else
            send_beat(mode, i == 0, pick_sample(ceiling));
      end
   endtask

   initial begin
      int          budget;
      int          len;
      int unsigned cells;
      int unsigned choice;
      logic [15:0] fixed_peak;

      sb = new();
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_GRAYSCALE_MODE;
      csr_wdata        <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset registers: zero maximum, then ramp segments and their bounds
      send_beat(MODE_PAINT, 1'b1, 16'd1234);
      send_beat(MODE_MEASURE, 1'b1, 16'hFFFF);
      send_beat(MODE_MEASURE, 1'b0, 16'h0000);
      send_beat(MODE_PAINT, 1'b1, 16'd0);
      send_beat(MODE_PAINT, 1'b0, 16'hFFFF);
      send_beat(MODE_PAINT, 1'b0, 16'd16383);
      send_beat(MODE_PAINT, 1'b0, 16'd16384);
      send_beat(MODE_PAINT, 1'b0, 16'd32767);
      send_beat(MODE_PAINT, 1'b0, 16'd32768);
      send_beat(MODE_PAINT, 1'b0, 16'd49151);
      send_beat(MODE_PAINT, 1'b0, 16'd49152);

      // grayscale, fixed max with saturation, writes off the frame corner
      configure(1'b1, 1'b1, 16'd1000, 11'd2, 11'd2, 10'd1023, 10'd1023);
      send_beat(MODE_PAINT, 1'b1, 16'd0);
      send_beat(MODE_PAINT, 1'b0, 16'd2000);
      send_beat(MODE_PAINT, 1'b0, 16'd500);
      send_beat(MODE_PAINT, 1'b0, 16'd999);

      // zero fixed max, zero width acts as one column
      configure(1'b0, 1'b1, 16'd0, 11'd0, 11'd1, 10'd0, 10'd0);
      send_beat(MODE_MEASURE, 1'b1, 16'd5);
      send_beat(MODE_PAINT, 1'b0, 16'd7);
      send_beat(MODE_PAINT, 1'b1, 16'hFFFF);

      // grid shrunk under a running counter
      configure(1'b0, 1'b0, 16'hFFFF, 11'd4, 11'd8, 10'd0, 10'd0);
      for (int i = 0; i < 6; i++) send_beat(MODE_PAINT, i == 0, 16'($urandom));
      configure(1'b0, 1'b0, 16'hFFFF, 11'd1, 11'd3, 10'd0, 10'd0);
      send_beat(MODE_PAINT, 1'b0, 16'($urandom));
      send_beat(MODE_PAINT, 1'b0, 16'($urandom));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 4))
            0: fixed_peak = 16'd0;
            1: fixed_peak = 16'hFFFF;
            2: fixed_peak = 16'($urandom_range(1, 255));
            default: fixed_peak = 16'($urandom);
         endcase
         configure($urandom_range(0, 1), $urandom_range(0, 2) == 0, fixed_peak,
                   pick_dim(), pick_dim(),
                   10'($urandom_range(0, 2) == 0 ? $urandom_range(1016, 1023)
                                                 : $urandom_range(0, 1023)),
                   10'($urandom_range(0, 2) == 0 ? $urandom_range(1016, 1023)
                                                 : $urandom_range(0, 1023)));
         idling = (phase < QUIET_PHASE) && ($urandom_range(0, 3) != 0);
         if (phase == 2) begin
            idling           = 1'b1;
            hold_off_pending = 1'b1;
         end
         budget = $urandom_range(55, 80);
         while (budget > 0) begin
            cells  = pixel_scoreboard::grid_span(sb.grid_cols) *
                     pixel_scoreboard::grid_span(sb.grid_rows);
            len    = (cells <= 64) ? cells : $urandom_range(8, 40);
            choice = $urandom_range(0, 9);
            if (choice <= 6) begin
               len = (2 * len > budget) ? (budget + 1) / 2 : len;
               run_pass(MODE_MEASURE, len);
               run_pass(MODE_PAINT, len);
               budget -= 2 * len;
            end else if (choice <= 8) begin
               len = (len > budget) ? budget : len;
               run_pass(MODE_PAINT, len);
               budget -= len;
            end else begin
               len = $urandom_range(1, 10);
               for (int i = 0; i < len; i++)
                  send_beat($urandom_range(0, 1), $urandom_range(0, 3) == 0, 16'($urandom));
               budget -= len;
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/hcp_pkg.sv
rtl/core/heatmap_colormap_painter.sv
verif/testbench.sv
